[hw/rtl/plc_pkg.sv]
// Package for the piecewise-linear calibrator: sizes, codes and shared types.
// No dependencies.
package plc_pkg;
  localparam int MAX_POINTS = 16;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int RES_W = 20;
  localparam int RD_W = 32;
  localparam int DIV_W = 53;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0, MODE_ADD = 3'd1, MODE_CAL = 3'd2, MODE_CONV = 3'd3, MODE_RAW = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_STATE = 2'd1, ST_RANGE = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CAL_NONE = 2'd0, CAL_PEND = 2'd1, CAL_DONE = 2'd2
  } cal_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADDRD, S_ADDCHK, S_SHIFT, S_SHWR, S_CALRD, S_CAL,
    S_CVRD, S_CVCHK, S_MUL, S_DIV, S_DIVW, S_OUT
  } fsm_t;

  typedef struct packed {
    logic               start;
    logic signed [53:0] num;
    logic        [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [53:0] quo;
  } div_rsp_t;
endpackage

[hw/rtl/plc_if.sv]
// Valid/ready channel interfaces for the calibrator.
// Depends on plc_pkg.
interface plc_in_if import plc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       mode;
  logic [RES_W-1:0] resistance;
  logic signed [RD_W-1:0] reading;
  modport source (output valid, mode, resistance, reading, input ready);
  modport sink (input valid, mode, resistance, reading, output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             drive_valid;
  logic [RES_W-1:0] drive_resistance;
  modport source (output valid, status, drive_valid, drive_resistance, input ready);
  modport sink (input valid, status, drive_valid, drive_resistance, output ready);
endinterface

[hw/rtl/plc_div.sv]
// Restoring signed-by-positive floor divider, one quotient bit per cycle.
// Depends on plc_pkg.
module plc_div import plc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [33:0]       rem_r, rem_nxt;
  logic [32:0]       den_r, den_nxt;
  logic [33:0]       trial;
  logic [DIV_W:0]    qf;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    trial = {rem_r[32:0], q_r[DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 6'(DIV_W);
      neg_nxt = req.num[53];
      q_nxt = req.num[53] ? DIV_W'(-req.num) : DIV_W'(req.num);
      rem_nxt = '0;
      den_nxt = req.den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // floor: negate magnitude, minus one on a nonzero remainder
  always_comb begin
    qf = {1'b0, q_r};
    if (neg_r) qf = -qf - ((rem_r != '0) ? (DIV_W+1)'(1) : '0);
  end
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = qf;
endmodule

[hw/rtl/piecewise_linear_calibrator.sv]
// Top level of the piecewise-linear calibrator: point memory, sequencer, divider.
// Depends on plc_pkg, plc_if, plc_div.
//
//  channel | dir | fields
//  in_     | in  | mode, resistance, reading
//  out_    | out | status, drive_valid, drive_resistance
//
// Add walks the table, one entry a cycle, then shifts entries up one at a time,
// from the top. Calibrate only marks the table calibrated, segments being derived
// from the points at convert time. Convert scans segments (one read a cycle),
// multiplies once and runs the divider. Reset is synchronous; the point memory
// needs no clearing. A stalled result holds the block in its output state.
module piecewise_linear_calibrator import plc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  plc_in_if.sink    in_ch,
  plc_out_if.source out_ch
);
  fsm_t state_r, state_nxt;
  logic [2:0]        mode_r;
  logic [RES_W-1:0]  res_r;
  logic signed [31:0] rd_r;
  cal_t              cal_r, cal_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              dv_r, dv_nxt;
  logic [RES_W-1:0]  dr_r, dr_nxt;
  logic signed [32:0] lo_r, lo_nxt;                 // last point reading
  logic [RES_W-1:0]  pr_r, pr_nxt;                  // previous point
  logic signed [31:0] pv_r, pv_nxt;
  logic              first_r, first_nxt;
  logic signed [21:0] slope_r, slope_nxt;
  logic [32:0]       run_r, run_nxt;
  logic signed [33:0] dv_diff_r, dv_diff_nxt;
  logic [RES_W-1:0]  rlo_r, rlo_nxt;
  logic signed [53:0] prod_r;
  div_req_t dreq;
  div_rsp_t drsp;

  // point memory: {resistance, reading}
  logic [RES_W+31:0] pmem [MAX_POINTS];
  logic [RES_W+31:0] prd_r;
  logic [IDX_W-1:0]  raddr;
  logic              pwe;
  logic [IDX_W-1:0]  waddr;
  logic [RES_W+31:0] wdata;
  always_ff @(posedge clk) begin
    if (pwe) pmem[waddr] <= wdata;
    prd_r <= pmem[raddr];
  end
  wire [RES_W-1:0]   m_res = prd_r[RES_W+31:32];
  wire signed [31:0] m_rd = prd_r[31:0];

  plc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [32:0] v_ext, cur_ext, prv_ext, seg_lo, seg_hi;
  logic [RES_W:0] qsum;
  always_comb begin
    state_nxt = state_r; cal_nxt = cal_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    st_nxt = st_r; dv_nxt = dv_r; dr_nxt = dr_r; lo_nxt = lo_r;
    pr_nxt = pr_r; pv_nxt = pv_r; first_nxt = first_r; slope_nxt = slope_r;
    run_nxt = run_r; dv_diff_nxt = dv_diff_r; rlo_nxt = rlo_r;
    raddr = idx_r[IDX_W-1:0]; pwe = 1'b0; waddr = idx_r[IDX_W-1:0];
    wdata = {res_r, rd_r};
    dreq.start = 1'b0; dreq.num = prod_r; dreq.den = run_r;
    v_ext = 33'(rd_r); cur_ext = 33'(m_rd); prv_ext = 33'(pv_r);
    seg_lo = (prv_ext <= cur_ext) ? prv_ext : cur_ext;
    seg_hi = (prv_ext <= cur_ext) ? cur_ext : prv_ext;
    qsum = 21'(drsp.quo) + {1'b0, rlo_r};
    in_ch.ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_DISP;
      S_DISP: begin
        st_nxt = ST_OK; dv_nxt = 1'b0; dr_nxt = '0; idx_nxt = '0; first_nxt = 1'b1;
        raddr = '0;
        state_nxt = S_OUT;
        case (mode_r)
          MODE_CLEAR: begin cal_nxt = CAL_NONE; cnt_nxt = '0; end
          MODE_ADD: state_nxt = S_ADDRD;
          MODE_CAL:
            if (cal_r == CAL_NONE || cnt_r < CNT_W'(2)) st_nxt = ST_STATE;
            else state_nxt = S_CALRD;
          MODE_CONV: begin
            raddr = IDX_W'(cnt_r - CNT_W'(1));
            if (cal_r != CAL_DONE || cnt_r < CNT_W'(2)) st_nxt = ST_STATE;
            else state_nxt = S_CVRD;
          end
          MODE_RAW: begin dv_nxt = 1'b1; dr_nxt = res_r; end
          default: ;
        endcase
      end
      // find insert slot: first entry with resistance >= new
      S_ADDRD: state_nxt = S_ADDCHK;
      S_ADDCHK: begin
        if (idx_r < cnt_r && m_res < res_r) begin
          idx_nxt = idx_r + CNT_W'(1); raddr = IDX_W'(idx_r + CNT_W'(1));
          state_nxt = S_ADDCHK;
        end else if (idx_r < cnt_r && m_res == res_r) begin
          pwe = 1'b1;
          if (cnt_r >= CNT_W'(2)) cal_nxt = CAL_PEND;
          state_nxt = S_OUT;
        end else if (cnt_r == CNT_W'(MAX_POINTS)) begin
          st_nxt = ST_FULL; state_nxt = S_OUT;
        end else begin
          // shift entries [idx, cnt) up by one, from the top
          rlo_nxt = RES_W'(idx_r);
          idx_nxt = cnt_r;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (idx_r == CNT_W'(rlo_r)) begin
          pwe = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r + CNT_W'(1) >= CNT_W'(2)) cal_nxt = CAL_PEND;
          state_nxt = S_OUT;
        end else begin
          raddr = IDX_W'(idx_r - CNT_W'(1));
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        pwe = 1'b1; wdata = prd_r;
        idx_nxt = idx_r - CNT_W'(1);
        state_nxt = S_SHIFT;
      end
      S_CALRD: begin
        // coefficients are derived from the points at convert time; nothing to store
        cal_nxt = CAL_DONE; state_nxt = S_OUT;
      end
      S_CVRD: begin
        lo_nxt = 33'(m_rd); state_nxt = S_CVCHK; raddr = '0;
      end
      S_CVCHK: begin
        // prd_r holds point 0 on the first visit, then point idx
        if (first_r) begin
          first_nxt = 1'b0;
          if (!((cur_ext <= lo_r) ? (v_ext >= cur_ext && v_ext <= lo_r)
                                   : (v_ext >= lo_r && v_ext <= cur_ext))) begin
            st_nxt = ST_RANGE; state_nxt = S_OUT;
          end
          pr_nxt = m_res; pv_nxt = m_rd; idx_nxt = CNT_W'(1); raddr = IDX_W'(1);
        end else if ((v_ext >= seg_lo && v_ext <= seg_hi) || idx_r + CNT_W'(1) == cnt_r)
        begin
          dv_nxt = 1'b1;
          if (prv_ext == cur_ext) begin
            dr_nxt = pr_r; state_nxt = S_OUT;
          end else begin
            rlo_nxt = (prv_ext < cur_ext) ? pr_r : m_res;
            slope_nxt = (prv_ext < cur_ext) ? (22'(m_res) - 22'(pr_r))
                                             : (22'(pr_r) - 22'(m_res));
            run_nxt = 33'(seg_hi - seg_lo);
            dv_diff_nxt = 34'(v_ext) - 34'(seg_lo);
            state_nxt = S_MUL;
          end
        end else begin
          pr_nxt = m_res; pv_nxt = m_rd;
          idx_nxt = idx_r + CNT_W'(1); raddr = IDX_W'(idx_r + CNT_W'(1));
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: begin dreq.start = 1'b1; state_nxt = S_DIVW; end
      S_DIVW: if (drsp.done) begin dr_nxt = qsum[RES_W-1:0]; state_nxt = S_OUT; end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cal_r <= CAL_NONE; cnt_r <= '0;
    end else begin
      state_r <= state_nxt; cal_r <= cal_nxt; cnt_r <= cnt_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode; res_r <= in_ch.resistance; rd_r <= in_ch.reading;
    end
    idx_r <= idx_nxt; st_r <= st_nxt; dv_r <= dv_nxt; dr_r <= dr_nxt;
    lo_r <= lo_nxt; pr_r <= pr_nxt; pv_r <= pv_nxt;
    first_r <= first_nxt; slope_r <= slope_nxt; run_r <= run_nxt;
    dv_diff_r <= dv_diff_nxt; rlo_r <= rlo_nxt;
    prod_r <= 54'(slope_r) * 54'(dv_diff_r);
  end

  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = st_r;
  assign out_ch.drive_valid = dv_r;
  assign out_ch.drive_resistance = dr_r;

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS)) else $error("point count overflow");
  a_div_out: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DIVW) else $error("divider result unexpected");
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.drive_valid |-> out_ch.drive_resistance == '0)
    else $error("drive without valid");
`endif
endmodule
